>>> src/sibps_pkg.sv
//------------------------------------------------------------------------------
// sibps_pkg: shared types and constants
// Opcodes, controller/datapath command and status structs.
//------------------------------------------------------------------------------
`default_nettype none
package sibps_pkg;
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_KICK = 3'd1;
    localparam logic [2:0] OP_SETP = 3'd2;
    localparam logic [2:0] OP_SETV = 3'd3;
    localparam logic [2:0] OP_ADDV = 3'd4;

    localparam logic [2:0] REG_BOX_X = 3'd0;
    localparam logic [2:0] REG_BOX_Y = 3'd1;
    localparam logic [2:0] REG_BOX_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS = 3'd3;
    localparam logic [2:0] REG_DAMP = 3'd4;
    localparam logic [2:0] REG_ELAST = 3'd5;
    localparam logic [2:0] REG_CEN = 3'd6;

    localparam logic [16:0] UNIT16 = 17'd65536;

    typedef struct packed {
        logic load;      // latch input item
        logic apply;     // apply op-specific state update (non-kick, non-tick)
        logic tick_mul;  // start tick multiply phase
        logic sq_start;  // start sum-of-squares / sqrt on input vector
        logic sqv_start; // start sum-of-squares / sqrt on velocity
        logic div_start; // start a division
        logic collide;   // collision step on one axis
        logic kick_add;  // add quotient to velocity
        logic norm;      // compute normalized ratio
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic kick_ok;
    } t_sts;
endpackage
`default_nettype wire

>>> src/sibps_ctrl.sv
//------------------------------------------------------------------------------
// sibps_ctrl: sequencer
// Steps one item through the datapath phases and runs the handshakes.
//------------------------------------------------------------------------------
`default_nettype none
module sibps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_op,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire sibps_pkg::t_sts   i_sts,
    output sibps_pkg::t_cmd        o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_OP    = 12'b000000000010,
        S_TICK  = 12'b000000000100,
        S_COLL  = 12'b000000001000,
        S_KSQ   = 12'b000000010000,
        S_KDIV  = 12'b000000100000,
        S_KWAIT = 12'b000001000000,
        S_VSQ   = 12'b000010000000,
        S_VWAIT = 12'b000100000000,
        S_NSET  = 12'b001000000000,
        S_NORM  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [2:0] r_op, n_op;
    logic r_ksq, n_ksq;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_op    = r_op;
        n_ksq   = r_ksq;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_op = i_op;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                if (r_op == sibps_pkg::OP_TICK) begin
                    o_cmd.tick_mul = 1'b1;
                    n_axis = 2'd0;
                    n_state = S_TICK;
                end else if (r_op == sibps_pkg::OP_KICK) begin
                    o_cmd.sq_start = 1'b1;
                    n_ksq = 1'b0;
                    n_state = S_KSQ;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state = S_VSQ;
                end
            end
            S_TICK: begin
                n_state = S_COLL;
            end
            S_COLL: begin
                o_cmd.collide = 1'b1;
                if (r_axis == 2'd2) n_state = S_VSQ;
                else n_axis = r_axis + 2'd1;
            end
            S_KSQ: begin
                if (i_sts.sqrt_done) begin
                    if (i_sts.kick_ok) begin
                        n_axis = 2'd0;
                        n_state = S_KDIV;
                    end else n_state = S_VSQ;
                end
            end
            S_KDIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_KWAIT;
            end
            S_KWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.kick_add = 1'b1;
                    if (r_axis == 2'd2) n_state = S_VSQ;
                    else begin
                        n_axis = r_axis + 2'd1;
                        n_state = S_KDIV;
                    end
                end
            end
            S_VSQ: begin
                o_cmd.sqv_start = 1'b1;
                n_state = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_sts.sqrt_done) n_state = S_NSET;
            end
            S_NSET: begin
                // speed register is settled here
                o_cmd.norm = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_op    <= '0;
            r_ksq   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_op    <= n_op;
            r_ksq   <= n_ksq;
        end
    end
endmodule
`default_nettype wire

>>> src/sibps_sqrt.sv
//------------------------------------------------------------------------------
// sibps_sqrt: iterative integer square root
// One result bit per radicand bit pair, one bit per cycle, 66-bit radicand.
//------------------------------------------------------------------------------
`default_nettype none
module sibps_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [65:0] i_val,
    output logic             o_done,
    output logic [32:0]      o_root
);
    logic [65:0] r_rad;
    logic [34:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [34:0] w_trial;
    logic [34:0] w_rem;

    assign w_rem   = {r_rem[32:0], r_rad[65:64]};
    assign w_trial = {r_root[32:0], 2'b01};
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[63:0], 2'b00};
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {r_root[31:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> src/sibps_div.sv
//------------------------------------------------------------------------------
// sibps_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module sibps_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo
);
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [64:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;

    assign w_sh  = {r_rem[63:0], r_num[63]};
    assign o_quo = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_num <= {r_num[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_num <= {r_num[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> src/sibps_dp.sv
//------------------------------------------------------------------------------
// sibps_dp: datapath
// State, configuration registers, multiply/collide logic, sqrt and divider.
//------------------------------------------------------------------------------
`default_nettype none
module sibps_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sibps_pkg::t_cmd      i_cmd,
    output sibps_pkg::t_sts           o_sts,
    input  wire logic                 i_cfg_valid,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [63:0]          i_cfg_data,
    input  wire logic [2:0]           i_op,
    input  wire logic signed [31:0]   i_vec_x,
    input  wire logic signed [31:0]   i_vec_y,
    input  wire logic signed [31:0]   i_vec_z,
    input  wire logic signed [31:0]   i_amount,
    input  wire logic [2:0]           i_norm_mode,
    output logic signed [31:0]        o_pos_x,
    output logic signed [31:0]        o_pos_y,
    output logic signed [31:0]        o_pos_z,
    output logic signed [31:0]        o_vel_x,
    output logic signed [31:0]        o_vel_y,
    output logic signed [31:0]        o_vel_z,
    output logic [31:0]               o_speed,
    output logic [16:0]               o_normalized
);
    localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;
    localparam logic [65:0] KICK_MIN = 66'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000);

    logic [63:0] r_box [3];
    logic [30:0] r_radius;
    logic [16:0] r_damp, r_elast;
    logic        r_cen;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_vec [3];
    logic signed [31:0] r_amt;
    logic [2:0]  r_op;
    logic [2:0]  r_mode;
    logic [32:0] r_len;
    logic        r_kneg;
    logic        r_nfix;
    logic [16:0] r_nval;
    logic        r_nneg;
    logic [31:0] r_speed;
    logic [16:0] r_norm;

    logic        w_sq_start;
    logic [65:0] w_sq_in;
    logic        w_sq_done;
    logic [32:0] w_root;
    logic        w_dv_start;
    logic [63:0] w_num, w_den;
    logic        w_dv_done;
    logic [63:0] w_quo;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7fffffff;
        if (v < -68'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [16:0] frac16(input logic [16:0] v);
        return (v > sibps_pkg::UNIT16) ? sibps_pkg::UNIT16 : v;
    endfunction

    function automatic logic [63:0] sq(input logic signed [31:0] a);
        logic [31:0] u;
        u = a[31] ? 32'(-a) : a;
        return 64'(u) * 64'(u);
    endfunction

    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];
    assign o_vel_x = r_vel[0];
    assign o_vel_y = r_vel[1];
    assign o_vel_z = r_vel[2];
    assign o_speed = r_speed;
    assign o_normalized = r_norm;

    // sum of squares registered at start; one wide sum of three squares
    logic [65:0] r_ssq;
    logic        r_sq_go;
    logic        r_sq_kick;
    assign w_sq_start = r_sq_go;
    assign w_sq_in    = r_ssq;

    sibps_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start), .i_val(w_sq_in),
        .o_done(w_sq_done), .o_root(w_root)
    );

    sibps_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dv_start), .i_num(w_num),
        .i_den(w_den), .o_done(w_dv_done), .o_quo(w_quo)
    );

    assign o_sts.sqrt_done = w_sq_done;
    assign o_sts.div_done  = w_dv_done;
    assign o_sts.kick_ok   = (r_ssq > KICK_MIN);

    // normalized ratio setup, combinational from state at norm command
    logic signed [35:0] w_rs_raw, w_rs;
    logic signed [35:0] w_nnum, w_nden;
    logic signed [31:0] w_lo_m, w_hi_m;
    logic [1:0] w_pi;
    logic [1:0] w_vi;
    always_comb begin
        w_rs_raw = 36'(signed'(r_box[0][63:32])) - 36'(signed'(r_box[0][31:0]))
                 + 36'(signed'(r_box[1][63:32])) - 36'(signed'(r_box[1][31:0]))
                 + 36'(signed'(r_box[2][63:32])) - 36'(signed'(r_box[2][31:0]));
        w_rs = ((48'(w_rs_raw) * 48'sd1000) < 48'(3 * ONE_Q)) ? 36'(30 * ONE_Q)
                                                               : w_rs_raw;
        w_pi = (r_mode[1:0] == 2'd3) ? 2'd0 : r_mode[1:0];
        w_vi = (r_mode == 3'd3) ? 2'd0 : (r_mode == 3'd4) ? 2'd1 : 2'd2;
        w_lo_m = r_box[w_pi][31:0];
        w_hi_m = r_box[w_pi][63:32];
        if (r_mode <= 3'd2) begin
            w_nnum = 36'(r_pos[w_pi]) - 36'(w_lo_m);
            w_nden = 36'(w_hi_m) - 36'(w_lo_m);
        end else if (r_mode <= 3'd5) begin
            w_nnum = 36'sd3 * 36'(r_vel[w_vi]) + w_rs;
            w_nden = 36'sd2 * w_rs;
        end else begin
            w_nnum = 36'sd3 * $signed({4'd0, r_speed});
            w_nden = w_rs;
        end
    end

    logic signed [35:0] w_pn, w_pd;
    always_comb begin
        w_pn = w_nden[35] ? -w_nnum : w_nnum;
        w_pd = w_nden[35] ? -w_nden : w_nden;
    end

    // divider operand selection
    logic signed [63:0] w_kprod;
    logic [1:0] w_ax;
    assign w_ax = i_cmd.axis;
    assign w_kprod = 64'(r_vec[w_ax]) * 64'(r_amt);
    always_comb begin
        w_dv_start = i_cmd.div_start;
        if (i_cmd.norm) begin
            w_num = {12'd0, w_pn[35:0], 16'd0};
            w_den = 64'(w_pd);
        end else begin
            w_num = w_kprod[63] ? 64'(-w_kprod) : w_kprod;
            w_den = 64'(r_len);
        end
    end

    // tick products and collision
    logic signed [63:0] w_step [3];
    logic signed [31:0] w_npos [3];
    logic signed [49:0] w_dprod [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_step[k]  = 64'(r_amt) * 64'(r_vel[k]);
            w_npos[k]  = sat32(68'(r_pos[k]) + 68'(w_step[k] >>> FRAC_BITS));
            w_dprod[k] = 50'(r_vel[k]) * 50'(signed'({1'b0, frac16(r_damp)}));
        end
    end

    logic signed [33:0] w_r, w_lo, w_hi;
    logic signed [33:0] w_p;
    logic signed [49:0] w_eprod;
    logic signed [31:0] w_rv;
    always_comb begin
        w_r  = (r_radius == '0) ? ONE_Q : 34'(signed'({1'b0, r_radius}));
        w_lo = 34'(signed'(r_box[w_ax][31:0]));
        w_hi = 34'(signed'(r_box[w_ax][63:32]));
        w_p  = 34'(r_pos[w_ax]);
        w_rv = r_vel[w_ax];
        w_eprod = -(50'(w_rv) * 50'(signed'({1'b0, frac16(r_elast)})));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_box[k] <= 64'h000A0000_FFF60000;
                r_pos[k] <= '0;
                r_vel[k] <= '0;
            end
            r_radius <= 31'd65536;
            r_damp   <= 17'd64881;
            r_elast  <= 17'd52429;
            r_cen    <= 1'b1;
            r_sq_go  <= 1'b0;
        end else begin
            r_sq_go <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sibps_pkg::REG_BOX_X:  r_box[0] <= i_cfg_data;
                    sibps_pkg::REG_BOX_Y:  r_box[1] <= i_cfg_data;
                    sibps_pkg::REG_BOX_Z:  r_box[2] <= i_cfg_data;
                    sibps_pkg::REG_RADIUS: r_radius <= i_cfg_data[30:0];
                    sibps_pkg::REG_DAMP:   r_damp <= i_cfg_data[16:0];
                    sibps_pkg::REG_ELAST:  r_elast <= i_cfg_data[16:0];
                    sibps_pkg::REG_CEN:    r_cen <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_op == sibps_pkg::OP_SETP) r_pos[k] <= r_vec[k];
                    else if (r_op == sibps_pkg::OP_SETV) r_vel[k] <= r_vec[k];
                    else if (r_op == sibps_pkg::OP_ADDV)
                        r_vel[k] <= sat32(68'(r_vel[k]) + 68'(r_vec[k]));
                end
            end
            if (i_cmd.tick_mul) begin
                for (int k = 0; k < 3; k++) begin
                    r_pos[k] <= w_npos[k];
                    r_vel[k] <= sat32(68'(w_dprod[k] >>> 16));
                end
            end
            if (i_cmd.collide && r_cen) begin
                if (w_p - w_r < w_lo) begin
                    r_pos[w_ax] <= sat32(68'(w_lo + w_r));
                    r_vel[w_ax] <= sat32(68'(w_eprod >>> 16));
                end else if (w_p + w_r > w_hi) begin
                    r_pos[w_ax] <= sat32(68'(w_hi - w_r));
                    r_vel[w_ax] <= sat32(68'(w_eprod >>> 16));
                end
            end
            if (i_cmd.kick_add) begin
                r_vel[w_ax] <= sat32(68'(r_vel[w_ax])
                    + (r_kneg ? -68'(signed'({1'b0, w_quo})) : 68'(signed'({1'b0, w_quo}))));
            end
            if (i_cmd.sq_start) begin
                r_ssq <= 66'(sq(r_vec[0])) + 66'(sq(r_vec[1])) + 66'(sq(r_vec[2]));
                r_sq_go <= 1'b1;
                r_sq_kick <= 1'b1;
            end
            if (i_cmd.sqv_start) begin
                r_ssq <= 66'(sq(r_vel[0])) + 66'(sq(r_vel[1])) + 66'(sq(r_vel[2]));
                r_sq_go <= 1'b1;
                r_sq_kick <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vec[0] <= i_vec_x;
            r_vec[1] <= i_vec_y;
            r_vec[2] <= i_vec_z;
            r_amt    <= i_amount;
            r_op     <= i_op;
            r_mode   <= i_norm_mode;
        end
        if (w_sq_done) begin
            if (r_sq_kick) r_len <= w_root;
            else r_speed <= (w_root[32]) ? 32'hffffffff : w_root[31:0];
        end
        if (i_cmd.div_start && !i_cmd.norm) r_kneg <= w_kprod[63];
        if (i_cmd.norm) begin
            r_nneg <= 1'b0;
            if (r_mode == 3'd7) begin
                r_nfix <= 1'b1; r_nval <= 17'd32768;
            end else if (w_nden == '0) begin
                r_nfix <= 1'b1; r_nval <= (w_nnum > 0) ? sibps_pkg::UNIT16 : 17'd0;
            end else if (w_pn <= 0) begin
                r_nfix <= 1'b1; r_nval <= 17'd0;
            end else if (w_pn >= w_pd) begin
                r_nfix <= 1'b1; r_nval <= sibps_pkg::UNIT16;
            end else begin
                r_nfix <= 1'b0; r_nval <= '0;
            end
        end
        if (w_dv_done && !r_nneg) begin
            r_norm <= r_nfix ? r_nval : w_quo[16:0];
        end
    end
endmodule
`default_nettype wire

>>> src/sphere_in_box_physics_step.sv
// Each item runs a 33-iteration square root for speed and a 64-iteration restoring
// divider for the normalized value; a tick adds the multiply and per-axis collide
// steps, and a kick adds a length square root and, above the length floor, three
// more divisions. One item in flight: the next beat is taken only once the result
// has been accepted.
// Synchronous active-low reset: box +/-10.0, radius 1.0, position and velocity zeroed.
//------------------------------------------------------------------------------
// sphere_in_box_physics_step: damped bouncing sphere top level
// Sequencer plus datapath joined by command/status structs.
//------------------------------------------------------------------------------
`default_nettype none
module sphere_in_box_physics_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic signed [31:0] i_amount,
    input  wire logic [2:0]         i_norm_mode,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_vel_x,
    output logic signed [31:0]      o_vel_y,
    output logic signed [31:0]      o_vel_z,
    output logic [31:0]             o_speed,
    output logic [16:0]             o_normalized,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    sibps_pkg::t_cmd w_cmd;
    sibps_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    sibps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .o_valid(o_valid), .i_ready(i_ready), .i_sts(w_sts),
        .o_cmd(w_cmd)
    );

    sibps_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_op(i_op), .i_vec_x(i_vec_x), .i_vec_y(i_vec_y), .i_vec_z(i_vec_z),
        .i_amount(i_amount), .i_norm_mode(i_norm_mode),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_vel_x(o_vel_x), .o_vel_y(o_vel_y), .o_vel_z(o_vel_z),
        .o_speed(o_speed), .o_normalized(o_normalized)
    );
endmodule
`default_nettype wire
